FILE: src/ntcc_pkg.sv
// Shared types and constants for the number-to-character-cell formatter.
// No dependencies; used by every module under src.
package ntcc_pkg;

  localparam int TEXT_COLUMNS_DEF = 16;
  localparam int TEXT_LINES_DEF   = 4;
  localparam int CELL_LIMIT       = 16;
  localparam int QUEUE_DEPTH      = 2;
  localparam int DEC_DIGITS       = 10;

  // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h41;
  localparam logic [6:0] CHAR_PLUS  = 7'h2B;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  typedef enum logic [1:0] {
    OP_UDEC = 2'd0,
    OP_SDEC = 2'd1,
    OP_HEX  = 2'd2,
    OP_BIN  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  text_line;
    logic [4:0]  start_column;
    logic [31:0] value;
    logic [5:0]  digit_count;
  } num_t;

  typedef struct packed {
    logic [2:0] cell_line;
    logic [4:0] cell_column;
    logic [6:0] char_code;
    logic       last_cell;
  } chr_t;

  // classified item waiting for the back end
  typedef struct packed {
    op_t         op;
    logic [2:0]  line;
    logic [4:0]  start;
    logic [31:0] mag;
    logic        neg;
    logic [5:0]  count;
    logic        skip0;     // first cell falls on column 0
    logic [4:0]  n_cells;   // cells to emit, 1..CELL_LIMIT
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

FILE: src/ntcc_front.sv
// Front end: takes number beats, drops off-grid items, works out the
// magnitude and the visible cell window. Depends on ntcc_pkg.
module ntcc_front #(
  parameter int TEXT_COLUMNS = ntcc_pkg::TEXT_COLUMNS_DEF,
  parameter int TEXT_LINES   = ntcc_pkg::TEXT_LINES_DEF
) (
  input  logic            num_valid,
  output logic            num_ready,
  input  ntcc_pkg::num_t  num,
  input  ntcc_pkg::qstat_t qs,
  output logic            push,
  output ntcc_pkg::job_t  job
);

  localparam logic [4:0] LINES = 5'(TEXT_LINES);
  localparam logic [7:0] COLS  = 8'(TEXT_COLUMNS);
  localparam logic [7:0] LIMIT = 8'(ntcc_pkg::CELL_LIMIT);

  logic       line_ok;
  logic       signed_op;
  logic [7:0] cells;
  logic [7:0] kmin;
  logic [7:0] kmax;
  logic [7:0] kcol;
  logic [7:0] span;
  logic       keep;

  always_comb begin
    signed_op = (num.op == ntcc_pkg::OP_SDEC);
    line_ok   = ({2'b00, num.text_line} >= 5'd1) && ({2'b00, num.text_line} <= LINES);
    cells     = {2'b00, num.digit_count} + {7'd0, signed_op};
    kmin      = (num.start_column == 5'd0) ? 8'd1 : 8'd0;
    kcol      = COLS - {3'b000, num.start_column};
    kmax      = ((cells - 8'd1) < kcol) ? (cells - 8'd1) : kcol;
    span      = kmax - kmin + 8'd1;
    keep      = line_ok && (cells != 8'd0) && ({3'b000, num.start_column} <= COLS) &&
                (kmax >= kmin);

    job.op      = num.op;
    job.line    = num.text_line;
    job.start   = num.start_column;
    job.neg     = signed_op && num.value[31];
    job.mag     = job.neg ? (~num.value + 32'd1) : num.value;
    job.count   = num.digit_count;
    job.skip0   = (num.start_column == 5'd0);
    job.n_cells = (span > LIMIT) ? LIMIT[4:0] : span[4:0];
  end

  assign num_ready = !qs.full;
  assign push      = num_valid && num_ready && keep;

endmodule

FILE: src/ntcc_queue.sv
// Short job queue between front and back ends.
// Depends on ntcc_pkg for the job and status types.
module ntcc_queue #(
  parameter int DEPTH = ntcc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ntcc_pkg::job_t   wr_job,
  input  logic             pop,
  output ntcc_pkg::job_t   rd_job,
  output ntcc_pkg::qstat_t qs
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  ntcc_pkg::job_t slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (AW + 1)'(1);
        2'b01:   count <= count - (AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  assign rd_job   = slots[rd_ptr];
  assign qs.full  = (count == FULL_CNT);
  assign qs.empty = (count == '0);

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !qs.full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !qs.empty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue count out of range");
`endif

endmodule

FILE: src/ntcc_back.sv
// Back end: converts a decimal job to digits one per cycle (hex and binary
// skip this), then emits character cells through an output register. Depends on ntcc_pkg.
module ntcc_back (
  input  logic             clk,
  input  logic             rst,
  input  ntcc_pkg::qstat_t qs,
  input  ntcc_pkg::job_t   rd_job,
  output logic             pop,
  output logic             chr_valid,
  input  logic             chr_ready,
  output ntcc_pkg::chr_t   chr
);

  localparam int          DW       = $clog2(ntcc_pkg::DEC_DIGITS);
  localparam logic [DW-1:0] LAST_DIG = DW'(ntcc_pkg::DEC_DIGITS - 1);

  ntcc_pkg::back_state_t state, state_next;
  ntcc_pkg::job_t        job;
  logic [31:0]           work;
  logic [DW-1:0]         conv_idx;
  logic [3:0]            digits [ntcc_pkg::DEC_DIGITS];
  logic [6:0]            k;
  logic [4:0]            e;

  logic        load_cell;
  logic        last;
  logic        is_dec;
  logic [63:0] prod;
  logic [31:0] quo;
  logic [3:0]  q10_lo;
  logic [3:0]  dig;
  logic        lead;
  logic [6:0]  pos7;
  logic [5:0]  pos;
  logic [3:0]  dsel;
  logic [DW-1:0] didx;
  logic [6:0]  code;
  logic [6:0]  col;

  // one decimal digit per cycle by reciprocal multiply
  always_comb begin
    prod   = {32'd0, work} * {32'd0, ntcc_pkg::RECIP_TEN};
    quo    = 32'(prod[63:ntcc_pkg::RECIP_SHIFT]);
    q10_lo = {quo[0], 3'b000} + {quo[2:0], 1'b0};
    dig    = work[3:0] - q10_lo;
  end

  always_comb begin
    lead = (job.op == ntcc_pkg::OP_SDEC);
    pos7 = {1'b0, job.count} - 7'd1 - (k - {6'd0, lead});
    pos  = pos7[5:0];
    didx = (pos < 6'(ntcc_pkg::DEC_DIGITS)) ? pos[DW-1:0] : '0;
    unique case (job.op)
      ntcc_pkg::OP_HEX: dsel = (pos < 6'd8) ? job.mag[{pos[2:0], 2'b00} +: 4] : 4'd0;
      ntcc_pkg::OP_BIN: dsel = (pos < 6'd32) ? {3'b000, job.mag[pos[4:0]]} : 4'd0;
      default:          dsel = (pos < 6'(ntcc_pkg::DEC_DIGITS)) ? digits[didx] : 4'd0;
    endcase
    if (lead && (k == 7'd0)) begin
      code = job.neg ? ntcc_pkg::CHAR_MINUS : ntcc_pkg::CHAR_PLUS;
    end else if (dsel < 4'd10) begin
      code = ntcc_pkg::CHAR_ZERO + {3'b000, dsel};
    end else begin
      code = ntcc_pkg::CHAR_A + {3'b000, dsel} - 7'd10;
    end
    col = {2'b00, job.start} + k;
  end

  // next state
  always_comb begin
    is_dec     = (rd_job.op == ntcc_pkg::OP_UDEC) || (rd_job.op == ntcc_pkg::OP_SDEC);
    state_next = state;
    unique case (state)
      ntcc_pkg::BK_IDLE: begin
        if (!qs.empty) begin
          state_next = is_dec ? ntcc_pkg::BK_CONV : ntcc_pkg::BK_EMIT;
        end
      end
      ntcc_pkg::BK_CONV: begin
        if (conv_idx == LAST_DIG) begin
          state_next = ntcc_pkg::BK_EMIT;
        end
      end
      ntcc_pkg::BK_EMIT: begin
        if (load_cell && last) begin
          state_next = ntcc_pkg::BK_IDLE;
        end
      end
      default: state_next = ntcc_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop       = (state == ntcc_pkg::BK_IDLE) && !qs.empty;
    load_cell = (state == ntcc_pkg::BK_EMIT) && (!chr_valid || chr_ready);
    last      = (e == job.n_cells - 5'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ntcc_pkg::BK_IDLE;
      chr_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_cell) begin
        chr_valid <= 1'b1;
      end else if (chr_ready) begin
        chr_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job      <= rd_job;
      work     <= rd_job.mag;
      conv_idx <= '0;
      k        <= {6'd0, rd_job.skip0};
      e        <= '0;
    end
    if (state == ntcc_pkg::BK_CONV) begin
      digits[conv_idx] <= dig;
      work             <= quo;
      conv_idx         <= conv_idx + DW'(1);
    end
    if (load_cell) begin
      chr.cell_line   <= job.line;
      chr.cell_column <= col[4:0];
      chr.char_code   <= code;
      chr.last_cell   <= last;
      k               <= k + 7'd1;
      e               <= e + 5'd1;
    end
  end

`ifndef SYNTHESIS
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ntcc_pkg::BK_EMIT) |-> (e < job.n_cells))
    else $error("cell index past job cell count");
  a_conv_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ntcc_pkg::BK_CONV) |-> (conv_idx <= LAST_DIG))
    else $error("digit index past last decimal digit");
  a_col_nonzero: assert property (@(posedge clk) disable iff (rst)
    load_cell |-> (col != 7'd0))
    else $error("cell emitted on column zero");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (load_cell && last) |=> (state == ntcc_pkg::BK_IDLE) && chr_valid && chr.last_cell)
    else $error("final cell not flagged or back end not idle");
`endif

endmodule

FILE: src/number_to_character_cells_top.sv
// Top level of the number-to-character-cell formatter.
// Instantiates ntcc_front, ntcc_queue and ntcc_back; types from ntcc_pkg.
//
//   channel | valid     | ready     | payload | beat
//   input   | num_valid | num_ready | num     | one number to format
//   output  | chr_valid | chr_ready | chr     | one character cell
//
// Decimal items are dequeued and turned into 10 digits (one reciprocal
// multiply each); hex and binary skip this. Up to 16 cells are then sent
// one per cycle unless stalled. Off-grid items are accepted and dropped.
// Reset (rst, synchronous) empties the queue and the output register.
// The front end keeps accepting while the queue has room, so a stalled
// output holds the back end only.
module number_to_character_cells_top #(
  parameter int TEXT_COLUMNS = ntcc_pkg::TEXT_COLUMNS_DEF,
  parameter int TEXT_LINES   = ntcc_pkg::TEXT_LINES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           num_valid,
  output logic           num_ready,
  input  ntcc_pkg::num_t num,
  output logic           chr_valid,
  input  logic           chr_ready,
  output ntcc_pkg::chr_t chr
);

  ntcc_pkg::qstat_t qs;
  ntcc_pkg::job_t   wr_job;
  ntcc_pkg::job_t   rd_job;
  logic             push;
  logic             pop;

  ntcc_front #(
    .TEXT_COLUMNS(TEXT_COLUMNS),
    .TEXT_LINES  (TEXT_LINES)
  ) u_front (
    .num_valid(num_valid),
    .num_ready(num_ready),
    .num      (num),
    .qs       (qs),
    .push     (push),
    .job      (wr_job)
  );

  ntcc_queue #(
    .DEPTH(ntcc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wr_job(wr_job),
    .pop   (pop),
    .rd_job(rd_job),
    .qs    (qs)
  );

  ntcc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .qs       (qs),
    .rd_job   (rd_job),
    .pop      (pop),
    .chr_valid(chr_valid),
    .chr_ready(chr_ready),
    .chr      (chr)
  );

endmodule
